/* sv/prod_pkg.sv */
// Shared types, constants and button remap for the pad report origin decoder.
package prod_pkg;

  localparam int DEFAULT_NUM_PORTS = 4;
  localparam int PORT_W            = 2;
  localparam int BUTTONS_W         = 13;
  localparam logic [7:0] PRESENT_MASK = 8'h30;
  localparam logic signed [8:0] STICK_MAX = 9'sd127;
  localparam logic signed [8:0] STICK_MIN = -9'sd128;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [7:0]        status;
    logic [7:0]        btn_lo;
    logic [7:0]        btn_hi;
    logic [7:0]        raw_stick_x;
    logic [7:0]        raw_stick_y;
    logic [7:0]        raw_sub_x;
    logic [7:0]        raw_sub_y;
    logic [7:0]        raw_trig_l;
    logic [7:0]        raw_trig_r;
  } record_t;

  // Rest position of one port: four stick bytes then two trigger bytes.
  typedef struct packed {
    logic [7:0] stick_x;
    logic [7:0] stick_y;
    logic [7:0] sub_x;
    logic [7:0] sub_y;
    logic [7:0] trig_l;
    logic [7:0] trig_r;
  } origin_t;

  typedef struct packed {
    logic [PORT_W-1:0]    out_port;
    logic                 present;
    logic [BUTTONS_W-1:0] buttons;
    logic signed [7:0]    stick_x;
    logic signed [7:0]    stick_y;
    logic signed [7:0]    sub_x;
    logic signed [7:0]    sub_y;
    logic [7:0]           trig_l;
    logic [7:0]           trig_r;
  } result_t;

  // Low byte: A,B,X,Y -> 8..11, d-pad left,right,down,up -> 0..3.
  // High byte: start -> 12, Z,R,L -> 4..6. Bit 7 stays clear.
  function automatic logic [BUTTONS_W-1:0] map_buttons(input logic [7:0] lo,
                                                        input logic [7:0] hi);
    return {hi[0], lo[3:0], 1'b0, hi[3:1], lo[7:4]};
  endfunction

endpackage

/* sv/prod_if.sv */
// Valid/ready channel interfaces for port records and decoded results.
interface prod_in_if;
  logic                          valid;
  logic                          ready;
  logic [prod_pkg::PORT_W-1:0]   port;
  logic [7:0]                    status;
  logic [7:0]                    btn_lo;
  logic [7:0]                    btn_hi;
  logic [7:0]                    raw_stick_x;
  logic [7:0]                    raw_stick_y;
  logic [7:0]                    raw_sub_x;
  logic [7:0]                    raw_sub_y;
  logic [7:0]                    raw_trig_l;
  logic [7:0]                    raw_trig_r;

  modport source (output valid, port, status, btn_lo, btn_hi, raw_stick_x, raw_stick_y,
                  raw_sub_x, raw_sub_y, raw_trig_l, raw_trig_r, input ready);
  modport sink   (input valid, port, status, btn_lo, btn_hi, raw_stick_x, raw_stick_y,
                  raw_sub_x, raw_sub_y, raw_trig_l, raw_trig_r, output ready);
  modport mon    (input valid, ready, port, status, btn_lo, btn_hi, raw_stick_x,
                  raw_stick_y, raw_sub_x, raw_sub_y, raw_trig_l, raw_trig_r);
endinterface

interface prod_out_if;
  logic                             valid;
  logic                             ready;
  logic [prod_pkg::PORT_W-1:0]      out_port;
  logic                             present;
  logic [prod_pkg::BUTTONS_W-1:0]   buttons;
  logic signed [7:0]                stick_x;
  logic signed [7:0]                stick_y;
  logic signed [7:0]                sub_x;
  logic signed [7:0]                sub_y;
  logic [7:0]                       trig_l;
  logic [7:0]                       trig_r;

  modport source (output valid, out_port, present, buttons, stick_x, stick_y, sub_x, sub_y,
                  trig_l, trig_r, input ready);
  modport sink   (input valid, out_port, present, buttons, stick_x, stick_y, sub_x, sub_y,
                  trig_l, trig_r, output ready);
  modport mon    (input valid, ready, out_port, present, buttons, stick_x, stick_y, sub_x,
                  sub_y, trig_l, trig_r);
endinterface

/* sv/prod_calc.sv */
// Combinational decode of one port record against the port's stored origin.
module prod_calc (
  input  prod_pkg::record_t rec,
  input  prod_pkg::origin_t org,
  input  logic              org_valid,
  input  logic              port_ok,
  output logic              present,
  output prod_pkg::result_t res
);

  prod_pkg::origin_t raw_org;
  prod_pkg::origin_t eff;

  function automatic logic signed [7:0] stick_delta(input logic [7:0] v,
                                                    input logic [7:0] o);
    logic signed [8:0] d;
    d = $signed({1'b0, v}) - $signed({1'b0, o});
    if (d > prod_pkg::STICK_MAX)      return prod_pkg::STICK_MAX[7:0];
    else if (d < prod_pkg::STICK_MIN) return prod_pkg::STICK_MIN[7:0];
    else                              return d[7:0];
  endfunction

  function automatic logic [7:0] trig_delta(input logic [7:0] v, input logic [7:0] o);
    return (v > o) ? 8'(v - o) : 8'd0;
  endfunction

  assign raw_org = '{stick_x: rec.raw_stick_x, stick_y: rec.raw_stick_y,
                     sub_x: rec.raw_sub_x, sub_y: rec.raw_sub_y,
                     trig_l: rec.raw_trig_l, trig_r: rec.raw_trig_r};

  // First present record after an absence becomes its own origin.
  assign eff     = org_valid ? org : raw_org;
  assign present = port_ok && ((rec.status & prod_pkg::PRESENT_MASK) != 8'h00);

  always_comb begin
    res          = '0;
    res.out_port = rec.port;
    if (present) begin
      res.present = 1'b1;
      res.buttons = prod_pkg::map_buttons(rec.btn_lo, rec.btn_hi);
      res.stick_x = stick_delta(rec.raw_stick_x, eff.stick_x);
      res.stick_y = stick_delta(rec.raw_stick_y, eff.stick_y);
      res.sub_x   = stick_delta(rec.raw_sub_x, eff.sub_x);
      res.sub_y   = stick_delta(rec.raw_sub_y, eff.sub_y);
      res.trig_l  = trig_delta(rec.raw_trig_l, eff.trig_l);
      res.trig_r  = trig_delta(rec.raw_trig_r, eff.trig_r);
    end
  end

endmodule

/* sv/pad_report_origin_decoder_top.sv */
// Top level of the pad report origin decoder: origin store and result register.
//
// Channels: "in" carries one controller-port record per transfer (port, status,
// two button bytes, four stick bytes, two trigger bytes); "out" carries one
// decoded result per record, in order. Both are valid/ready; a transfer
// happens on a rising edge with valid and ready high.
// Latency: the result of a record is offered on the cycle after its transfer.
// Throughput: one record per cycle while out.ready stays high. The whole decode (origin select, four
// saturating subtracts, two clamped subtracts, button remap) sits between the
// input pins and the single result register.
// The per-port origin lives in flip-flops: a valid bit and six bytes per port.
// A present record on a port with no valid origin captures its own analog
// bytes as origin and so reports zero deltas; an absent record drops the
// origin. Records for ports at or above NUM_PORTS report absent and leave
// all origins alone.
// Reset (synchronous, active high) empties the result register and clears
// every origin valid bit; origin bytes themselves need no reset.
// Receiver stall: the result holds steady while out.ready is low, and in.ready
// follows (!out.valid || out.ready), so a record is still taken in the very
// cycle a pending result leaves.
module pad_report_origin_decoder_top #(
  parameter int NUM_PORTS = prod_pkg::DEFAULT_NUM_PORTS
) (
  input  logic           clk,
  input  logic           rst,
  prod_in_if.sink        in,
  prod_out_if.source     out
);

  localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  prod_pkg::record_t rec;
  prod_pkg::result_t res_next;
  prod_pkg::result_t res;
  prod_pkg::origin_t origin [NUM_PORTS];
  logic [NUM_PORTS-1:0] origin_valid;
  logic                 out_valid;
  logic                 take;
  logic                 port_ok;
  logic                 present;
  logic [IDX_W-1:0]     idx;

  assign rec = '{port: in.port, status: in.status, btn_lo: in.btn_lo, btn_hi: in.btn_hi,
                 raw_stick_x: in.raw_stick_x, raw_stick_y: in.raw_stick_y,
                 raw_sub_x: in.raw_sub_x, raw_sub_y: in.raw_sub_y,
                 raw_trig_l: in.raw_trig_l, raw_trig_r: in.raw_trig_r};

  // Output register frees whenever its content leaves.
  assign in.ready = !out_valid || out.ready;
  assign take     = in.valid && in.ready;

  // Ports beyond the store are never written; idx only matters when port_ok.
  assign port_ok = 32'(rec.port) < NUM_PORTS;
  assign idx     = IDX_W'(rec.port);

  prod_calc u_calc (
    .rec       (rec),
    .org       (origin[idx]),
    .org_valid (origin_valid[idx]),
    .port_ok   (port_ok),
    .present   (present),
    .res       (res_next)
  );

  // Origin bookkeeping: drop on absence, capture on first presence.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_valid <= '0;
    end else if (take && port_ok) begin
      if (!present) begin
        origin_valid[idx] <= 1'b0;
      end else if (!origin_valid[idx]) begin
        origin_valid[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && port_ok && present && !origin_valid[idx]) begin
      origin[idx] <= '{stick_x: rec.raw_stick_x, stick_y: rec.raw_stick_y,
                       sub_x: rec.raw_sub_x, sub_y: rec.raw_sub_y,
                       trig_l: rec.raw_trig_l, trig_r: rec.raw_trig_r};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in.ready) begin
      out_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign out.valid    = out_valid;
  assign out.out_port = res.out_port;
  assign out.present  = res.present;
  assign out.buttons  = res.buttons;
  assign out.stick_x  = res.stick_x;
  assign out.stick_y  = res.stick_y;
  assign out.sub_x    = res.sub_x;
  assign out.sub_y    = res.sub_y;
  assign out.trig_l   = res.trig_l;
  assign out.trig_r   = res.trig_r;

endmodule

/* sv/prod_check.sv */
// Port-level checks for the pad report origin decoder, bound to the top level.
module prod_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [prod_pkg::PORT_W-1:0]    in_port,
  input logic [7:0]                     in_status,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [prod_pkg::PORT_W-1:0]    out_port,
  input logic                           out_present,
  input logic [prod_pkg::BUTTONS_W-1:0] out_buttons,
  input logic [7:0]                     out_stick_x,
  input logic [7:0]                     out_stick_y,
  input logic [7:0]                     out_sub_x,
  input logic [7:0]                     out_sub_y,
  input logic [7:0]                     out_trig_l,
  input logic [7:0]                     out_trig_r
);

  // A stalled result must stay valid and keep its port, presence, buttons, stick_x and trig_l.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_port) &&
      $stable(out_present) && $stable(out_buttons) && $stable(out_stick_x) &&
      $stable(out_trig_l))
    else $error("result changed while stalled");

  // Every transfer in gives a result for the same port on the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid && (out_port == $past(in_port)))
    else $error("result missing or port mismatch after input transfer");

  // An absent port reports nothing else.
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_present |-> (out_buttons == '0) && (out_stick_x == '0) &&
      (out_stick_y == '0) && (out_sub_x == '0) && (out_sub_y == '0) &&
      (out_trig_l == '0) && (out_trig_r == '0))
    else $error("absent result carries nonzero fields");

  // Empty status bits never produce a present result.
  a_status_absent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_status[5:4] == 2'b00) |=> !out_present)
    else $error("present reported for empty status");

  // No result can be pending straight out of reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind pad_report_origin_decoder_top prod_check u_prod_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in.valid),
  .in_ready    (in.ready),
  .in_port     (in.port),
  .in_status   (in.status),
  .out_valid   (out.valid),
  .out_ready   (out.ready),
  .out_port    (out.out_port),
  .out_present (out.present),
  .out_buttons (out.buttons),
  .out_stick_x (out.stick_x),
  .out_stick_y (out.stick_y),
  .out_sub_x   (out.sub_x),
  .out_sub_y   (out.sub_y),
  .out_trig_l  (out.trig_l),
  .out_trig_r  (out.trig_r)
);
